>>> rtl/core/pnp_pkg.sv
// ---------------------------------------------------------------------------
// pnp_pkg: shared definitions of the port number pool
// Action and status codes, register indexes, controller states and the
// result record passed to the output buffer.
// ---------------------------------------------------------------------------
package pnp_pkg;

  // Action codes carried on the input channel
  localparam logic [1:0] ACT_INIT      = 2'd0;
  localparam logic [1:0] ACT_TAKE_ANY  = 2'd1;
  localparam logic [1:0] ACT_TAKE_SPEC = 2'd2;
  localparam logic [1:0] ACT_GIVE      = 2'd3;

  // Status codes carried on the result channel
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_RANGE_STEP = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_TAKE,
    S_SRCH
  } state_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] port;
  } result_t;

endpackage

>>> rtl/core/pnp_ifs.sv
// ---------------------------------------------------------------------------
// pnp_ifs: channel interfaces of the port number pool
// Request channel (action, value) and result channel (status, port), each a
// valid/ready channel with a source and a sink side.
// ---------------------------------------------------------------------------
interface pnp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface pnp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] port;

  modport source (output valid, output status, output port, input ready);
  modport sink   (input valid, input status, input port, output ready);
endinterface

>>> rtl/core/pnp_result_buf.sv
// ---------------------------------------------------------------------------
// pnp_result_buf: result output register with one skid entry
// Holds a finished result while the consumer stalls, so the controller can
// take and finish one further request in the meantime.
// ---------------------------------------------------------------------------
module pnp_result_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  pnp_pkg::result_t res,
  output logic             skid_full,
  pnp_out_if.source        out_ch
);

  logic             out_v_r, out_v_nxt;
  pnp_pkg::result_t out_r, out_nxt;
  logic             skid_v_r, skid_v_nxt;
  pnp_pkg::result_t skid_r, skid_nxt;
  logic             out_free;

  assign out_free = !out_v_r || out_ch.ready;

  // Advance the output register, refill from the skid entry first
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = res_valid;
        skid_nxt   = res;
      end else begin
        out_v_nxt = res_valid;
        out_nxt   = res;
      end
    end else if (res_valid) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign skid_full     = skid_v_r;
  assign out_ch.valid  = out_v_r;
  assign out_ch.status = out_r.status;
  assign out_ch.port   = out_r.port;

endmodule

>>> rtl/core/port_number_pool_top.sv
// ---------------------------------------------------------------------------
// port_number_pool_top: circular free-list allocator of 16-bit port numbers
// Slot store in one synchronous RAM, take and give-back pointers, ahead flag.
// ---------------------------------------------------------------------------
// One request is handled at a time; every request gives exactly one result.
// Give back is one RAM write. Take any reads the slot at the take pointer
// through the registered RAM read and hands it out. Take specific scans the
// slots from the take pointer, one RAM read per cycle. Init writes the pool
// numbers one per cycle through the single RAM write port. The RAM is not
// cleared after reset: a slot is only read after an init has written it.
// Register writes take effect at the next init. A finished result may wait in
// the output stage while the next request is already accepted.
module port_number_pool_top #(
  parameter int POOL_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  pnp_in_if.sink      in_ch,
  pnp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  // Configuration registers
  logic [15:0] range_low_r, range_high_r, range_step_r;

  // Pool state
  pnp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   take_r, take_nxt;
  logic [AW-1:0]   give_r, give_nxt;
  logic            ahead_r, ahead_nxt;

  // Request and walk registers
  logic [15:0]     value_r, value_nxt;
  logic [16:0]     fill_acc_r, fill_acc_nxt;
  logic [CW-1:0]   fill_idx_r, fill_idx_nxt;
  logic [15:0]     fill_hi_r, fill_hi_nxt;
  logic [15:0]     fill_step_r, fill_step_nxt;
  logic [AW-1:0]   scan_addr_r, scan_addr_nxt;
  logic            scan_done_r, scan_done_nxt;
  logic            pv_r, pv_nxt;
  logic [AW-1:0]   paddr_r, paddr_nxt;
  logic            plast_r, plast_nxt;
  logic            first_r, first_nxt;
  logic [15:0]     head_r, head_nxt;

  // Slot RAM
  logic [15:0]     slot_mem [POOL_DEPTH];
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata;
  logic [15:0]     rd_data_r;

  // Result path
  logic             res_valid;
  pnp_pkg::result_t res;
  logic             skid_full;

  // Decode helpers
  logic            accept;
  logic            pool_empty, pool_full;
  logic [AW-1:0]   give_adv, scan_adv;
  logic [16:0]     fill_sum;
  logic [CW-1:0]   fill_idx_inc;
  logic            fill_done;
  logic [15:0]     head_val;
  logic            srch_hit, srch_end;
  logic [15:0]     init_lo, init_hi;

  // Step a pointer round the circular store of n slots
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW + 1)'(p) + (CW + 1)'(1);
    if (s >= {1'b0, n}) begin
      return '0;
    end
    return s[AW-1:0];
  endfunction

  assign in_ch.ready = (state_r == pnp_pkg::S_IDLE) && !skid_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pool_empty = (count_r == '0) || (ahead_r && (take_r == give_r));
  assign pool_full  = (count_r == '0) || (!ahead_r && (give_r == take_r));
  assign give_adv   = adv(give_r, count_r);
  assign scan_adv   = adv(scan_addr_r, count_r);

  // Order the range ends for init
  assign init_lo = (range_low_r > range_high_r) ? range_high_r : range_low_r;
  assign init_hi = (range_low_r > range_high_r) ? range_low_r : range_high_r;

  // Fill walk: stop once the next number passes the top or the store is full
  assign fill_sum     = fill_acc_r + 17'(fill_step_r);
  assign fill_idx_inc = fill_idx_r + CW'(1);
  assign fill_done    = (fill_sum > {1'b0, fill_hi_r}) || (fill_idx_inc == DEPTH_C);

  // Search compare: the first slot read is the one at the take pointer
  assign head_val = first_r ? rd_data_r : head_r;
  assign srch_hit = pv_r && (rd_data_r == value_r);
  assign srch_end = pv_r && (srch_hit || plast_r);

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= 16'd0;
      range_high_r <= 16'hffff;
      range_step_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pnp_pkg::REG_RANGE_LOW:  range_low_r  <= cfg_data;
        pnp_pkg::REG_RANGE_HIGH: range_high_r <= cfg_data;
        pnp_pkg::REG_RANGE_STEP: range_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pnp_pkg::S_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            pnp_pkg::ACT_INIT:      state_nxt = pnp_pkg::S_FILL;
            pnp_pkg::ACT_TAKE_ANY:  state_nxt = pool_empty ? pnp_pkg::S_IDLE : pnp_pkg::S_TAKE;
            pnp_pkg::ACT_TAKE_SPEC: state_nxt = pool_empty ? pnp_pkg::S_IDLE : pnp_pkg::S_SRCH;
            default:                state_nxt = pnp_pkg::S_IDLE;
          endcase
        end
      end
      pnp_pkg::S_FILL: if (fill_done) state_nxt = pnp_pkg::S_IDLE;
      pnp_pkg::S_TAKE: state_nxt = pnp_pkg::S_IDLE;
      pnp_pkg::S_SRCH: if (srch_end) state_nxt = pnp_pkg::S_IDLE;
      default:         state_nxt = pnp_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM controls and results
  always_comb begin
    count_nxt     = count_r;
    take_nxt      = take_r;
    give_nxt      = give_r;
    ahead_nxt     = ahead_r;
    value_nxt     = value_r;
    fill_acc_nxt  = fill_acc_r;
    fill_idx_nxt  = fill_idx_r;
    fill_hi_nxt   = fill_hi_r;
    fill_step_nxt = fill_step_r;
    scan_addr_nxt = scan_addr_r;
    scan_done_nxt = scan_done_r;
    pv_nxt        = pv_r;
    paddr_nxt     = paddr_r;
    plast_nxt     = plast_r;
    first_nxt     = first_r;
    head_nxt      = head_r;
    mem_we        = 1'b0;
    mem_waddr     = give_r;
    mem_wdata     = in_ch.value;
    mem_re        = 1'b0;
    mem_raddr     = take_r;
    res_valid     = 1'b0;
    res.status    = pnp_pkg::ST_OK;
    res.port      = 16'd0;

    unique case (state_r)
      pnp_pkg::S_IDLE: begin
        if (accept) begin
          value_nxt = in_ch.value;
          case (in_ch.action)
            pnp_pkg::ACT_INIT: begin
              fill_acc_nxt  = {1'b0, init_lo};
              fill_idx_nxt  = '0;
              fill_hi_nxt   = init_hi;
              fill_step_nxt = (range_step_r == 16'd0) ? 16'd1 : range_step_r;
            end
            pnp_pkg::ACT_TAKE_ANY: begin
              if (pool_empty) begin
                res_valid  = 1'b1;
                res.status = pnp_pkg::ST_EXHAUSTED;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = take_r;
              end
            end
            pnp_pkg::ACT_TAKE_SPEC: begin
              if (pool_empty) begin
                res_valid  = 1'b1;
                res.status = pnp_pkg::ST_EXHAUSTED;
              end else begin
                scan_addr_nxt = take_r;
                scan_done_nxt = 1'b0;
                pv_nxt        = 1'b0;
                first_nxt     = 1'b1;
              end
            end
            default: begin
              // Give back: refuse into a full pool
              res_valid = 1'b1;
              if (pool_full) begin
                res.status = pnp_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = give_r;
                mem_wdata = in_ch.value;
                give_nxt  = give_adv;
                if (take_r == give_adv) ahead_nxt = 1'b0;
              end
            end
          endcase
        end
      end

      pnp_pkg::S_FILL: begin
        // Write one pool number per cycle in ascending order
        mem_we    = 1'b1;
        mem_waddr = fill_idx_r[AW-1:0];
        mem_wdata = fill_acc_r[15:0];
        if (fill_done) begin
          count_nxt = fill_idx_inc;
          take_nxt  = '0;
          give_nxt  = '0;
          ahead_nxt = 1'b0;
          res_valid = 1'b1;
        end else begin
          fill_acc_nxt = fill_sum;
          fill_idx_nxt = fill_idx_inc;
        end
      end

      pnp_pkg::S_TAKE: begin
        // Hand out the slot at the take pointer
        res_valid = 1'b1;
        res.port  = rd_data_r;
        take_nxt  = adv(take_r, count_r);
        ahead_nxt = 1'b1;
      end

      pnp_pkg::S_SRCH: begin
        // Compare the slot read last cycle
        if (pv_r) begin
          first_nxt = 1'b0;
          head_nxt  = head_val;
          if (srch_hit) begin
            mem_we    = 1'b1;
            mem_waddr = paddr_r;
            mem_wdata = head_val;
            take_nxt  = adv(take_r, count_r);
            ahead_nxt = 1'b1;
            res_valid = 1'b1;
          end else if (plast_r) begin
            res_valid  = 1'b1;
            res.status = pnp_pkg::ST_NOT_FOUND;
          end
        end
        // Issue the next read until the give-back pointer is reached
        if (!scan_done_r) begin
          mem_re        = 1'b1;
          mem_raddr     = scan_addr_r;
          pv_nxt        = 1'b1;
          paddr_nxt     = scan_addr_r;
          plast_nxt     = (scan_adv == give_r);
          scan_addr_nxt = scan_adv;
          scan_done_nxt = (scan_adv == give_r);
        end else begin
          pv_nxt = 1'b0;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pnp_pkg::S_IDLE;
      count_r <= '0;
      take_r  <= '0;
      give_r  <= '0;
      ahead_r <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      take_r  <= take_nxt;
      give_r  <= give_nxt;
      ahead_r <= ahead_nxt;
      pv_r    <= pv_nxt;
    end
  end

  // Walk and request registers, no reset
  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    fill_acc_r  <= fill_acc_nxt;
    fill_idx_r  <= fill_idx_nxt;
    fill_hi_r   <= fill_hi_nxt;
    fill_step_r <= fill_step_nxt;
    scan_addr_r <= scan_addr_nxt;
    scan_done_r <= scan_done_nxt;
    paddr_r     <= paddr_nxt;
    plast_r     <= plast_nxt;
    first_r     <= first_nxt;
    head_r      <= head_nxt;
  end

  // Slot RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_raddr];
    end
  end

  pnp_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .skid_full (skid_full),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/core/pnp_checker.sv
// ---------------------------------------------------------------------------
// pnp_checker: port-level checks of the port number pool
// Watches the channel ports of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module pnp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_port
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_port))
    else $error("result changed while stalled");

  // Drive port to zero on every failed request
  a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pnp_pkg::ST_OK) |-> out_port == 16'd0)
    else $error("non-zero port with failure status");

  // Stay busy in the cycle after an init transfer, while the fill runs
  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == pnp_pkg::ACT_INIT) |=> !in_ready)
    else $error("request taken during init fill");

  // Drop any result during reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind port_number_pool_top pnp_checker u_pnp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_action  (in_ch.action),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_port   (out_ch.port)
);
